/* rtl/vmnp_pkg.sv */
// Package for the vector magnitude / normal projection block.
// Field widths, output limits, operation codes and the stage tag type.
// No dependencies.
package vmnp_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int NORMAL_BITS = 16;
  localparam int OUT_BITS    = 25;
  localparam int OUT_MAX     = 14529496;

  localparam logic OP_MAG  = 1'b0;
  localparam logic OP_PROJ = 1'b1;

  typedef struct packed {
    logic vld;
    logic op;
    logic zero;
    logic neg;
  } tag_t;

endpackage

/* rtl/vector_magnitude_and_normal_projection.sv */
// Top level of the vector magnitude / normal projection block.
// Uses vmnp_pkg, vmnp_front and vmnp_root_stage.
//
// Input channel: in_valid / in_stall with op, comp_x/y/z, norm_x/y/z.
// Output channel: out_valid / out_stall with value.
// A transaction moves on a rising edge with valid high and stall low.
// op 0 returns floor(sqrt(x^2+y^2+z^2)); op 1 returns the dot product
// with the unit normal, rounded to nearest, ties away from zero; a zero
// normal returns 0. Results saturate to +-OUT_MAX.
// The pipeline is five front stages, one root stage per result bit,
// one output register. Throughput is one transaction per cycle while
// out_stall does not hold the output; the root recurrence is unrolled
// into one registered stage per bit.
// The whole pipeline advances together: in_stall is high exactly when a
// result is held on the output and out_stall is high, so nothing is lost
// or repeated. Synchronous reset clears all valid bits.
module vector_magnitude_and_normal_projection #(
  parameter int SAMPLE_BITS = vmnp_pkg::SAMPLE_BITS,
  parameter int NORMAL_BITS = vmnp_pkg::NORMAL_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          op,
  input  logic signed [SAMPLE_BITS-1:0] comp_x,
  input  logic signed [SAMPLE_BITS-1:0] comp_y,
  input  logic signed [SAMPLE_BITS-1:0] comp_z,
  input  logic signed [NORMAL_BITS-1:0] norm_x,
  input  logic signed [NORMAL_BITS-1:0] norm_y,
  input  logic signed [NORMAL_BITS-1:0] norm_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [vmnp_pkg::OUT_BITS-1:0] value
);

  localparam int S  = SAMPLE_BITS;
  localparam int N  = NORMAL_BITS;
  localparam int RW = 2*S + 2*N + 2;
  localparam int PW = S + 2*N + 3;
  localparam int OB = vmnp_pkg::OUT_BITS;

  logic en;

  vmnp_pkg::tag_t          tag_c  [0:S];
  logic [RW-1:0]           rem_c  [0:S];
  logic signed [PW-1:0]    acc_c  [0:S];
  logic [2*N-1:0]          step_c [0:S];
  logic [S-1:0]            q_c    [0:S];

  logic [S-1:0]            q_sat;
  logic [OB-1:0]           mag;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  vmnp_front #(.S(S), .N(N)) u_front (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (in_valid),
    .op     (op),
    .comp_x (comp_x),
    .comp_y (comp_y),
    .comp_z (comp_z),
    .norm_x (norm_x),
    .norm_y (norm_y),
    .norm_z (norm_z),
    .tag_o  (tag_c[0]),
    .rem_o  (rem_c[0]),
    .acc_o  (acc_c[0]),
    .step_o (step_c[0])
  );

  assign q_c[0] = '0;

  for (genvar i = 0; i < S; i++) begin : g_root
    vmnp_root_stage #(.S(S), .N(N), .K(S - 1 - i)) u_stage (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .tag_i  (tag_c[i]),
      .rem_i  (rem_c[i]),
      .acc_i  (acc_c[i]),
      .step_i (step_c[i]),
      .q_i    (q_c[i]),
      .tag_o  (tag_c[i+1]),
      .rem_o  (rem_c[i+1]),
      .acc_o  (acc_c[i+1]),
      .step_o (step_c[i+1]),
      .q_o    (q_c[i+1])
    );
  end

  assign q_sat = q_c[S];
  assign mag = (33'(q_sat) > 33'(vmnp_pkg::OUT_MAX)) ? OB'(vmnp_pkg::OUT_MAX) : OB'(q_sat);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= tag_c[S].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (tag_c[S].op == vmnp_pkg::OP_PROJ && tag_c[S].zero) begin
        value <= '0;
      end else if (tag_c[S].op == vmnp_pkg::OP_PROJ && tag_c[S].neg) begin
        value <= -signed'(mag);
      end else begin
        value <= signed'(mag);
      end
    end
  end

  a_stall_only_when_held: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall not tied to a held result");

  a_value_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (value <= OB'(vmnp_pkg::OUT_MAX) && value >= -OB'(vmnp_pkg::OUT_MAX)))
    else $error("result beyond saturation limit");

  a_zero_normal: assert property (@(posedge clk) disable iff (rst)
    (en && tag_c[S].vld && tag_c[S].op == vmnp_pkg::OP_PROJ && tag_c[S].zero)
      |=> (out_valid && value == '0))
    else $error("zero normal did not give zero");

  a_mag_nonneg: assert property (@(posedge clk) disable iff (rst)
    (en && tag_c[S].vld && tag_c[S].op == vmnp_pkg::OP_MAG) |=> !value[OB-1])
    else $error("negative magnitude");

endmodule

/* rtl/vmnp_front.sv */
// Front stages: products, sums, absolute dot product, split square.
// Produces the remainder, step and trial-offset seeds for the root stages.
// Depends on vmnp_pkg.
module vmnp_front #(
  parameter int S = vmnp_pkg::SAMPLE_BITS,
  parameter int N = vmnp_pkg::NORMAL_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic                      op,
  input  logic signed [S-1:0]       comp_x,
  input  logic signed [S-1:0]       comp_y,
  input  logic signed [S-1:0]       comp_z,
  input  logic signed [N-1:0]       norm_x,
  input  logic signed [N-1:0]       norm_y,
  input  logic signed [N-1:0]       norm_z,
  output vmnp_pkg::tag_t            tag_o,
  output logic [2*S+2*N+1:0]        rem_o,
  output logic signed [S+2*N+2:0]   acc_o,
  output logic [2*N-1:0]            step_o
);

  localparam int RW = 2*S + 2*N + 2;
  localparam int PW = S + 2*N + 3;
  localparam int AW = S + N;
  localparam int L  = AW / 2;
  localparam int H  = AW - L;

  vmnp_pkg::tag_t t1, t2, t3, t4;

  logic signed [2*S-1:0]   cxx, cyy, czz;
  logic signed [S+N-1:0]   dx, dy, dz;
  logic signed [2*N-1:0]   nxx, nyy, nzz;

  logic signed [2*S+1:0]   sq2, sq3, sq4;
  logic signed [S+N+1:0]   d2;
  logic signed [2*N+1:0]   nn2, nn3, nn4;

  logic [AW-1:0]           ad;
  logic [2*H-1:0]          hh;
  logic [H+L-1:0]          hl;
  logic [2*L-1:0]          ll;
  logic [RW-1:0]           dsq;
  logic [RW-1:0]           dsq4;
  logic                    below;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1 <= '0;
      t2 <= '0;
      t3 <= '0;
      t4 <= '0;
      tag_o <= '0;
    end else if (en) begin
      t1 <= '{vld: in_vld, op: op, zero: 1'b0, neg: 1'b0};
      t2 <= t1;
      t3 <= '{vld: t2.vld, op: t2.op, zero: (nn2 == '0), neg: d2[S+N+1]};
      t4 <= t3;
      tag_o <= '{vld: t4.vld, op: t4.op, zero: t4.zero | below, neg: t4.neg};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cxx <= comp_x * comp_x;
      cyy <= comp_y * comp_y;
      czz <= comp_z * comp_z;
      dx  <= comp_x * norm_x;
      dy  <= comp_y * norm_y;
      dz  <= comp_z * norm_z;
      nxx <= norm_x * norm_x;
      nyy <= norm_y * norm_y;
      nzz <= norm_z * norm_z;

      sq2 <= (2*S+2)'(cxx) + (2*S+2)'(cyy) + (2*S+2)'(czz);
      d2  <= (S+N+2)'(dx) + (S+N+2)'(dy) + (S+N+2)'(dz);
      nn2 <= (2*N+2)'(nxx) + (2*N+2)'(nyy) + (2*N+2)'(nzz);

      ad  <= d2[S+N+1] ? AW'(-d2) : AW'(d2);
      sq3 <= sq2;
      nn3 <= nn2;

      hh  <= ad[AW-1:L] * ad[AW-1:L];
      hl  <= ad[AW-1:L] * ad[L-1:0];
      ll  <= ad[L-1:0] * ad[L-1:0];
      sq4 <= sq3;
      nn4 <= nn3;

      if (t4.op == vmnp_pkg::OP_PROJ) begin
        rem_o  <= dsq4 - RW'(nn4);
        acc_o  <= -(PW'(nn4));
        step_o <= nn4[2*N-1:0];
      end else begin
        rem_o  <= RW'(sq4) << 2;
        acc_o  <= '0;
        step_o <= (2*N)'(1);
      end
    end
  end

  assign dsq = (RW'(hh) << (2*L)) + (RW'(hl) << (L+1)) + RW'(ll);
  assign dsq4 = dsq << 2;
  // projection that rounds to zero: 4*d^2 < |n|^2
  assign below = (t4.op == vmnp_pkg::OP_PROJ) && (dsq4 < RW'(nn4));

endmodule

/* rtl/vmnp_root_stage.sv */
// One bit of the shared root / rounded-quotient recurrence.
// Tries bit K of the result against the remaining budget.
// Depends on vmnp_pkg.
module vmnp_root_stage #(
  parameter int S = vmnp_pkg::SAMPLE_BITS,
  parameter int N = vmnp_pkg::NORMAL_BITS,
  parameter int K = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  vmnp_pkg::tag_t            tag_i,
  input  logic [2*S+2*N+1:0]        rem_i,
  input  logic signed [S+2*N+2:0]   acc_i,
  input  logic [2*N-1:0]            step_i,
  input  logic [S-1:0]              q_i,
  output vmnp_pkg::tag_t            tag_o,
  output logic [2*S+2*N+1:0]        rem_o,
  output logic signed [S+2*N+2:0]   acc_o,
  output logic [2*N-1:0]            step_o,
  output logic [S-1:0]              q_o
);

  localparam int RW = 2*S + 2*N + 2;
  localparam int PW = S + 2*N + 3;
  localparam int DW = PW + S + 2;

  logic [PW-1:0] base;
  logic [DW-1:0] delta;
  logic          take;

  assign base  = unsigned'(acc_i + (PW'(step_i) << K));
  assign delta = DW'(base) << (K + 2);
  assign take  = delta <= DW'(rem_i);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_o <= '0;
    end else if (en) begin
      tag_o <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      step_o <= step_i;
      if (take) begin
        rem_o  <= rem_i - delta[RW-1:0];
        acc_o  <= acc_i + (PW'(step_i) << (K + 1));
        q_o    <= q_i | (S'(1) << K);
      end else begin
        rem_o  <= rem_i;
        acc_o  <= acc_i;
        q_o    <= q_i;
      end
    end
  end

endmodule

/* dv/vector_magnitude_and_normal_projection_tb.sv */
// Testbench for vector_magnitude_and_normal_projection: directed table, then random
// transactions with random stalls on both sides, checked against an in-bench predictor.
// Depends on vmnp_pkg and the RTL top level.
module vector_magnitude_and_normal_projection_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM = 1930;
  localparam int CALM_FROM  = 1750;
  localparam int SB = vmnp_pkg::SAMPLE_BITS;
  localparam int NB = vmnp_pkg::NORMAL_BITS;
  localparam int OB = vmnp_pkg::OUT_BITS;

  typedef struct {
    logic                 op;
    logic signed [SB-1:0] cx, cy, cz;
    logic signed [NB-1:0] nx, ny, nz;
    bit                   typed;
    logic signed [OB-1:0] val;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic op = vmnp_pkg::OP_MAG;
  logic signed [SB-1:0] comp_x = '0, comp_y = '0, comp_z = '0;
  logic signed [NB-1:0] norm_x = '0, norm_y = '0, norm_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OB-1:0] value;

  logic signed [OB-1:0] pending_values[$];
  int  errors = 0;
  bit  calm = 1'b0;

  vector_magnitude_and_normal_projection u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [OB-1:0] predict_value(vec_row_t r);
    longint cx, cy, cz, nx, ny, nz, d, res;
    logic [127:0] nn, rhs, lhs, a, lo, hi, mid, ad;
    cx = r.cx; cy = r.cy; cz = r.cz;
    nx = r.nx; ny = r.ny; nz = r.nz;
    if (r.op == vmnp_pkg::OP_MAG) begin
      res = longint'(floor_sqrt(cx * cx + cy * cy + cz * cz));
      if (res > vmnp_pkg::OUT_MAX) res = vmnp_pkg::OUT_MAX;
    end else begin
      nn = nx * nx + ny * ny + nz * nz;
      if (nn == 0) begin
        res = 0;
      end else begin
        d = cx * nx + cy * ny + cz * nz;
        ad = (d < 0) ? -d : d;
        rhs = 4 * ad * ad;
        lo = 0;
        hi = 128'd1 << (SB + 1);
        while (lo < hi) begin
          mid = lo + (hi - lo + 1) / 2;
          a = 2 * mid - 1;
          lhs = a * a * nn;
          if (lhs <= rhs) lo = mid;
          else hi = mid - 1;
        end
        if (lo > vmnp_pkg::OUT_MAX) lo = vmnp_pkg::OUT_MAX;
        res = (d < 0) ? -longint'(lo) : longint'(lo);
      end
    end
    return res[OB-1:0];
  endfunction

  function automatic logic [31:0] pick_field(int w);
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: v = {1'b0, {31{1'b1}}};
      1: v = 32'h8000_0000;
      2: v = 0;
      3: v = $urandom_range(0, 15) << (32 - w);
      default: v = $urandom;
    endcase
    return v >> (32 - w) | ((v[31] ? 32'hFFFF_FFFF : 0) << w);
  endfunction

  function automatic vec_row_t random_row();
    vec_row_t r;
    r.op = $urandom_range(0, 1) ? vmnp_pkg::OP_PROJ : vmnp_pkg::OP_MAG;
    r.cx = SB'(pick_field(SB));
    r.cy = SB'(pick_field(SB));
    r.cz = SB'(pick_field(SB));
    r.nx = NB'(pick_field(NB));
    r.ny = NB'(pick_field(NB));
    r.nz = NB'(pick_field(NB));
    if ($urandom_range(0, 9) == 0) begin
      r.nx = NB'(int'($urandom_range(0, 2)) - 1);
      r.ny = NB'(int'($urandom_range(0, 2)) - 1);
      r.nz = NB'(int'($urandom_range(0, 2)) - 1);
    end
    r.typed = 1'b0;
    r.val = '0;
    return r;
  endfunction

  vec_row_t vec_table[20] = '{
    '{vmnp_pkg::OP_MAG,  0, 0, 0, 0, 0, 0, 1, 0},
    '{vmnp_pkg::OP_MAG,  3, 4, 0, 0, 0, 0, 1, 5},
    '{vmnp_pkg::OP_MAG,  -3, 0, -4, 0, 0, 0, 1, 5},
    '{vmnp_pkg::OP_MAG,  3, 4, 0, -32768, 32767, 7, 1, 5},
    '{vmnp_pkg::OP_MAG,  -8388608, -8388608, -8388608, 0, 0, 0, 1, 14529495},
    '{vmnp_pkg::OP_MAG,  8388607, 8388607, 8388607, 0, 0, 0, 0, 0},
    '{vmnp_pkg::OP_MAG,  -8388608, 0, 0, 0, 0, 0, 1, 8388608},
    '{vmnp_pkg::OP_PROJ, 1234, -99, 8388607, 0, 0, 0, 1, 0},
    '{vmnp_pkg::OP_PROJ, -8388608, -8388608, -8388608, 0, 0, 0, 1, 0},
    '{vmnp_pkg::OP_PROJ, 5, 0, 0, 1, 0, 0, 1, 5},
    '{vmnp_pkg::OP_PROJ, 5, 0, 0, -1, 0, 0, 1, -5},
    '{vmnp_pkg::OP_PROJ, -8388608, 0, 0, -32768, 0, 0, 1, 8388608},
    '{vmnp_pkg::OP_PROJ, -8388608, 0, 0, 32767, 0, 0, 1, -8388608},
    '{vmnp_pkg::OP_PROJ, -8388608, -8388608, -8388608, -32768, -32768, -32768, 1, 14529495},
    '{vmnp_pkg::OP_PROJ, 8388607, 8388607, 8388607, 32767, 32767, 32767, 0, 0},
    '{vmnp_pkg::OP_PROJ, 8388607, -8388608, 8388607, -32768, 32767, -32768, 0, 0},
    '{vmnp_pkg::OP_PROJ, 1, 1, 1, 2, 2, 1, 1, 2},
    '{vmnp_pkg::OP_PROJ, 1, 0, 0, 0, 1, 0, 1, 0},
    '{vmnp_pkg::OP_PROJ, 1, 0, 0, 1, 1, 1, 0, 0},
    '{vmnp_pkg::OP_PROJ, 7, -3, 11, 3, -4, 12, 0, 0}
  };

  task automatic send_row(vec_row_t r);
    logic signed [OB-1:0] exp_val;
    exp_val = predict_value(r);
    if (r.typed && exp_val !== r.val) begin
      $display("%0t predictor disagrees with table: expected %0d actual %0d",
               $time, r.val, exp_val);
      errors++;
    end
    in_valid <= 1'b1;
    op <= r.op;
    comp_x <= r.cx; comp_y <= r.cy; comp_z <= r.cz;
    norm_x <= r.nx; norm_y <= r.ny; norm_z <= r.nz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_values.push_back(r.typed ? r.val : exp_val);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    foreach (vec_table[i]) send_row(vec_table[i]);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == CALM_FROM) calm = 1'b1;
      send_row(random_row());
    end
    in_valid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // receiver: random stall bursts, one long hold-off to back up the pipe
  initial begin
    @(negedge rst);
    repeat (200) @(posedge clk);
    out_stall <= 1'b1;
    repeat (150) @(posedge clk);
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_values.size() == 0) begin
        $display("%0t unexpected transaction: expected none actual %0d", $time, value);
        errors++;
      end else begin
        if (value !== pending_values[0]) begin
          $display("%0t value mismatch: expected %0d actual %0d",
                   $time, pending_values[0], value);
          errors++;
        end
        void'(pending_values.pop_front());
      end
    end
  end

  initial begin
    #(8 * 400000);
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
